// ===== src/rhbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhbc_pkg: shared definitions for the hue band centroid block
// Frame geometry, field widths, register indexes and the types that pass
// between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package rhbc_pkg;

    // Frame geometry.
    localparam int FRAME_ROWS = 120;
    localparam int FRAME_COLS = 160;

    // Field widths.
    localparam int PIX_W   = 16;
    localparam int CH_W    = 8;
    localparam int SCALE_W = 8;
    localparam int PROD_W  = CH_W + SCALE_W;
    localparam int OFF_W   = SCALE_W + 1;
    localparam int HUE_W   = 11;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int CNT_W   = 19;
    localparam int SUM_W   = 32;

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Job queue depth.
    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Divider step counts. The hue quotient is always below the sector
    // scale, so only the low CH_W quotient bits need to be developed.
    localparam int HDIV_STEPS = CH_W;
    localparam int CDIV_STEPS = SUM_W;
    localparam int HCNT_W     = $clog2(HDIV_STEPS);
    localparam int CCNT_W     = $clog2(CDIV_STEPS);

    // Centroid divider work register: remainder above, sum below.
    localparam int WORK_W = CNT_W + SUM_W;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_BAND_LOW     = 2'd0,
        REG_BAND_HIGH    = 2'd1,
        REG_SECTOR_SCALE = 2'd2,
        REG_NO_HUE_VALUE = 2'd3
    } reg_idx_t;

    // Configuration seen by the datapath. Hue bounds are two's complement.
    typedef struct packed {
        logic [HUE_W-1:0]   band_low;
        logic [HUE_W-1:0]   band_high;
        logic [HUE_W-1:0]   no_hue;
        logic [SCALE_W-1:0] sector_scale;
    } cfg_t;

    // Classified pixel handed from the front end to the back end.
    typedef struct packed {
        logic               ordered;
        logic               negate;
        logic [PROD_W-1:0]  num;
        logic [CH_W-1:0]    den;
        logic [OFF_W-1:0]   offset;
    } job_t;

endpackage

// ===== src/rhbc_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rhbc_pixel_if: pixel input channel
// Valid/ready channel that carries one RGB565 word.
// ----------------------------------------------------------------------------
interface rhbc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [rhbc_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

// ===== src/rhbc_result_if.sv =====
// ----------------------------------------------------------------------------
// rhbc_result_if: per-pixel result channel
// Valid/ready channel that carries the hue, band flag and frame summary.
// ----------------------------------------------------------------------------
interface rhbc_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [rhbc_pkg::HUE_W-1:0] hue;
    logic                              in_band;
    logic                              frame_done;
    logic [rhbc_pkg::ROW_W-1:0]        centroid_row;
    logic [rhbc_pkg::COL_W-1:0]        centroid_col;
    logic [rhbc_pkg::CNT_W-1:0]        band_count;
    logic                              centroid_valid;

    modport source (output valid, output hue, output in_band, output frame_done,
                    output centroid_row, output centroid_col, output band_count,
                    output centroid_valid, input ready);
    modport sink (input valid, input hue, input in_band, input frame_done,
                  input centroid_row, input centroid_col, input band_count,
                  input centroid_valid, output ready);
endinterface

// ===== src/rhbc_front.sv =====
// ----------------------------------------------------------------------------
// rhbc_front: pixel classifier
// Splits each RGB565 word into channels, finds the channel ordering and
// forms the scaled numerator, divisor, sign and sector offset of the hue.
// ----------------------------------------------------------------------------
module rhbc_front
(
    input  logic [rhbc_pkg::SCALE_W-1:0] sector_scale,
    rhbc_pixel_if.sink                   pix,
    output logic                         push_valid,
    input  logic                         push_ready,
    output rhbc_pkg::job_t               push_job
);

    logic [rhbc_pkg::CH_W-1:0]   red;
    logic [rhbc_pkg::CH_W-1:0]   green;
    logic [rhbc_pkg::CH_W-1:0]   blue;
    logic [rhbc_pkg::CH_W-1:0]   diff;
    logic [rhbc_pkg::PROD_W-1:0] product;

    // A word passes straight into the queue when it has room.
    assign push_valid = pix.valid;
    assign pix.ready  = push_ready;

    // Expand the channels to 8 bits.
    assign red   = {pix.pixel[4:0], 3'b000};
    assign green = {pix.pixel[10:5], 2'b00};
    assign blue  = {pix.pixel[15:11], 3'b000};

    // Pick the sector from the strict channel ordering.
    always_comb
    begin
        push_job         = '0;
        diff             = '0;
        push_job.ordered = 1'b1;
        priority if ((red > blue) && (blue > green))
        begin
            diff            = blue - green;
            push_job.negate = 1'b1;
            push_job.den    = red - green;
        end
        else if ((red > green) && (green > blue))
        begin
            diff         = green - blue;
            push_job.den = red - blue;
        end
        else if ((green > blue) && (blue > red))
        begin
            diff            = blue - red;
            push_job.den    = green - red;
            push_job.offset = {sector_scale, 1'b0};
        end
        else if ((green > red) && (red > blue))
        begin
            diff            = red - blue;
            push_job.negate = 1'b1;
            push_job.den    = green - blue;
            push_job.offset = {sector_scale, 1'b0};
        end
        else
        begin
            push_job.ordered = 1'b0;
        end
        push_job.num = product;
    end

    // Scale the channel difference by the sector width.
    assign product = rhbc_pkg::PROD_W'(diff) * rhbc_pkg::PROD_W'(sector_scale);

endmodule

// ===== src/rhbc_queue.sv =====
// ----------------------------------------------------------------------------
// rhbc_queue: job queue
// Short FIFO between the classifier and the back end so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module rhbc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rhbc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rhbc_pkg::job_t pop_job
);

    rhbc_pkg::job_t                  entry_reg [rhbc_pkg::QDEPTH];
    logic [rhbc_pkg::PTR_W-1:0]      wr_ptr_reg;
    logic [rhbc_pkg::PTR_W-1:0]      wr_ptr_next;
    logic [rhbc_pkg::PTR_W-1:0]      rd_ptr_reg;
    logic [rhbc_pkg::PTR_W-1:0]      rd_ptr_next;
    logic [rhbc_pkg::QCNT_W-1:0]     count_reg;
    logic [rhbc_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != rhbc_pkg::QCNT_W'(rhbc_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rhbc_pkg::PTR_W'(rhbc_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rhbc_pkg::PTR_W'(rhbc_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/rhbc_back.sv =====
// ----------------------------------------------------------------------------
// rhbc_back: hue divider, band accumulator and centroid divider
// Divides out the hue one quotient bit a cycle, tests it against the band,
// keeps the frame position and sums, and at the end of a frame divides the
// row and column sums by the count, one bit a cycle, into the output word.
// ----------------------------------------------------------------------------
module rhbc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  rhbc_pkg::cfg_t cfg,
    input  logic           job_valid,
    output logic           job_ready,
    input  rhbc_pkg::job_t job,
    rhbc_result_if.source  res
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_HDIV = 6'b000010,
        ST_HUE  = 6'b000100,
        ST_EVAL = 6'b001000,
        ST_CDIV = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // One restoring step of the centroid division: remainder above, the
    // dividend shifting out at the top of the low part, quotient bits in.
    function automatic logic [rhbc_pkg::WORK_W-1:0] cdiv_step(
        input logic [rhbc_pkg::WORK_W-1:0]   w,
        input logic [rhbc_pkg::CNT_W-1:0]    d
    );
        logic [rhbc_pkg::CNT_W:0] trial;
        logic [rhbc_pkg::CNT_W:0] diff;
        logic                     ge;
        trial = {w[rhbc_pkg::WORK_W-1 -: rhbc_pkg::CNT_W], w[rhbc_pkg::SUM_W-1]};
        diff  = trial - {1'b0, d};
        ge    = (trial >= {1'b0, d});
        return {(ge ? diff[rhbc_pkg::CNT_W-1:0] : trial[rhbc_pkg::CNT_W-1:0]),
                w[rhbc_pkg::SUM_W-2:0], ge};
    endfunction

    state_t                          state_reg, state_next;
    logic [rhbc_pkg::HCNT_W-1:0]     hcnt_reg, hcnt_next;
    logic [rhbc_pkg::CCNT_W-1:0]     ccnt_reg, ccnt_next;
    logic [rhbc_pkg::ROW_W-1:0]      row_idx_reg, row_idx_next;
    logic [rhbc_pkg::COL_W-1:0]      col_idx_reg, col_idx_next;
    logic [rhbc_pkg::SUM_W-1:0]      row_sum_reg, row_sum_next;
    logic [rhbc_pkg::SUM_W-1:0]      col_sum_reg, col_sum_next;
    logic [rhbc_pkg::CNT_W-1:0]      pcount_reg, pcount_next;
    logic                            out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [rhbc_pkg::PROD_W-1:0]     hwork_reg, hwork_next;
    logic [rhbc_pkg::CH_W-1:0]       den_reg, den_next;
    logic                            neg_reg, neg_next;
    logic                            ord_reg, ord_next;
    logic [rhbc_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [rhbc_pkg::HUE_W-1:0]      hue_reg, hue_next;
    logic                            inb_reg, inb_next;
    logic                            last_reg, last_next;
    logic [rhbc_pkg::WORK_W-1:0]     rwork_reg, rwork_next;
    logic [rhbc_pkg::WORK_W-1:0]     cwork_reg, cwork_next;
    logic [rhbc_pkg::CNT_W-1:0]      div_reg, div_next;
    logic [rhbc_pkg::CNT_W-1:0]      bcount_reg, bcount_next;
    logic                            cvalid_reg, cvalid_next;
    logic [rhbc_pkg::HUE_W-1:0]      o_hue_reg, o_hue_next;
    logic                            o_inb_reg, o_inb_next;
    logic                            o_done_reg, o_done_next;
    logic [rhbc_pkg::ROW_W-1:0]      o_row_reg, o_row_next;
    logic [rhbc_pkg::COL_W-1:0]      o_col_reg, o_col_next;
    logic [rhbc_pkg::CNT_W-1:0]      o_cnt_reg, o_cnt_next;
    logic                            o_cvalid_reg, o_cvalid_next;

    logic [rhbc_pkg::CH_W:0]         htrial;
    logic [rhbc_pkg::CH_W:0]         hdiff;
    logic                            hge;
    logic [rhbc_pkg::HUE_W-1:0]      qmag;
    logic                            in_band;
    logic                            at_last;
    logic                            at_row_end;
    logic [rhbc_pkg::SUM_W-1:0]      row_sum_add;
    logic [rhbc_pkg::SUM_W-1:0]      col_sum_add;
    logic [rhbc_pkg::CNT_W-1:0]      pcount_add;
    logic                            out_load;

    assign job_ready = (state_reg == ST_IDLE);

    // Hue division step: remainder in the high byte, dividend bits below.
    assign htrial = {hwork_reg[rhbc_pkg::PROD_W-1 -: rhbc_pkg::CH_W],
                     hwork_reg[rhbc_pkg::CH_W-1]};
    assign hdiff  = htrial - {1'b0, den_reg};
    assign hge    = (htrial >= {1'b0, den_reg});

    // Signed quotient magnitude for the hue.
    assign qmag = neg_reg ? -rhbc_pkg::HUE_W'(hwork_reg[rhbc_pkg::CH_W-1:0]) :
                  rhbc_pkg::HUE_W'(hwork_reg[rhbc_pkg::CH_W-1:0]);

    // Band test and running sums for the pixel under evaluation.
    assign in_band = ($signed(hue_reg) > $signed(cfg.band_low)) &&
                     ($signed(hue_reg) < $signed(cfg.band_high));
    assign row_sum_add = row_sum_reg + rhbc_pkg::SUM_W'(row_idx_reg);
    assign col_sum_add = col_sum_reg + rhbc_pkg::SUM_W'(col_idx_reg);
    assign pcount_add  = pcount_reg + 1'b1;
    assign at_row_end  = (col_idx_reg >= rhbc_pkg::COL_W'(rhbc_pkg::FRAME_COLS - 1));
    assign at_last     = (row_idx_reg >= rhbc_pkg::ROW_W'(rhbc_pkg::FRAME_ROWS - 1)) &&
                         at_row_end;

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || res.ready);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        hcnt_next      = hcnt_reg;
        ccnt_next      = ccnt_reg;
        row_idx_next   = row_idx_reg;
        col_idx_next   = col_idx_reg;
        row_sum_next   = row_sum_reg;
        col_sum_next   = col_sum_reg;
        pcount_next    = pcount_reg;
        hwork_next     = hwork_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        ord_next       = ord_reg;
        off_next       = off_reg;
        hue_next       = hue_reg;
        inb_next       = inb_reg;
        last_next      = last_reg;
        rwork_next     = rwork_reg;
        cwork_next     = cwork_reg;
        div_next       = div_reg;
        bcount_next    = bcount_reg;
        cvalid_next    = cvalid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    hwork_next = job.num;
                    den_next   = job.den;
                    neg_next   = job.negate;
                    ord_next   = job.ordered;
                    off_next   = job.offset;
                    hcnt_next  = '0;
                    state_next = job.ordered ? ST_HDIV : ST_HUE;
                end
            end
            ST_HDIV:
            begin
                hwork_next = {(hge ? hdiff[rhbc_pkg::CH_W-1:0] :
                                     htrial[rhbc_pkg::CH_W-1:0]),
                              hwork_reg[rhbc_pkg::CH_W-2:0], hge};
                hcnt_next  = hcnt_reg + 1'b1;
                if (hcnt_reg == rhbc_pkg::HCNT_W'(rhbc_pkg::HDIV_STEPS - 1))
                begin
                    state_next = ST_HUE;
                end
            end
            ST_HUE:
            begin
                hue_next   = ord_reg ? (qmag + rhbc_pkg::HUE_W'(off_reg)) : cfg.no_hue;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                inb_next  = in_band;
                last_next = at_last;
                if (at_last)
                begin
                    // Close the frame and, if any pixel fell in the band, start the centroid division.
                    rwork_next   = {{rhbc_pkg::CNT_W{1'b0}},
                                    (in_band ? row_sum_add : row_sum_reg)};
                    cwork_next   = {{rhbc_pkg::CNT_W{1'b0}},
                                    (in_band ? col_sum_add : col_sum_reg)};
                    div_next     = in_band ? pcount_add : pcount_reg;
                    bcount_next  = in_band ? pcount_add : pcount_reg;
                    cvalid_next  = in_band || (pcount_reg != '0);
                    ccnt_next    = '0;
                    row_sum_next = '0;
                    col_sum_next = '0;
                    pcount_next  = '0;
                    row_idx_next = '0;
                    col_idx_next = '0;
                    state_next   = (in_band || (pcount_reg != '0)) ? ST_CDIV : ST_OUT;
                end
                else
                begin
                    if (in_band)
                    begin
                        row_sum_next = row_sum_add;
                        col_sum_next = col_sum_add;
                        pcount_next  = pcount_add;
                    end
                    bcount_next = '0;
                    cvalid_next = 1'b0;
                    if (at_row_end)
                    begin
                        col_idx_next = '0;
                        row_idx_next = row_idx_reg + 1'b1;
                    end
                    else
                    begin
                        col_idx_next = col_idx_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_CDIV:
            begin
                rwork_next = cdiv_step(rwork_reg, div_reg);
                cwork_next = cdiv_step(cwork_reg, div_reg);
                ccnt_next  = ccnt_reg + 1'b1;
                if (ccnt_reg == rhbc_pkg::CCNT_W'(rhbc_pkg::CDIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: holds a finished word until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_hue_next     = o_hue_reg;
        o_inb_next     = o_inb_reg;
        o_done_next    = o_done_reg;
        o_row_next     = o_row_reg;
        o_col_next     = o_col_reg;
        o_cnt_next     = o_cnt_reg;
        o_cvalid_next  = o_cvalid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            o_hue_next     = hue_reg;
            o_inb_next     = inb_reg;
            o_done_next    = last_reg;
            o_row_next     = cvalid_reg ? rwork_reg[rhbc_pkg::ROW_W-1:0] : '0;
            o_col_next     = cvalid_reg ? cwork_reg[rhbc_pkg::COL_W-1:0] : '0;
            o_cnt_next     = bcount_reg;
            o_cvalid_next  = cvalid_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hcnt_reg      <= '0;
            ccnt_reg      <= '0;
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            row_sum_reg   <= '0;
            col_sum_reg   <= '0;
            pcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hcnt_reg      <= hcnt_next;
            ccnt_reg      <= ccnt_next;
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            row_sum_reg   <= row_sum_next;
            col_sum_reg   <= col_sum_next;
            pcount_reg    <= pcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        hwork_reg    <= hwork_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        ord_reg      <= ord_next;
        off_reg      <= off_next;
        hue_reg      <= hue_next;
        inb_reg      <= inb_next;
        last_reg     <= last_next;
        rwork_reg    <= rwork_next;
        cwork_reg    <= cwork_next;
        div_reg      <= div_next;
        bcount_reg   <= bcount_next;
        cvalid_reg   <= cvalid_next;
        o_hue_reg    <= o_hue_next;
        o_inb_reg    <= o_inb_next;
        o_done_reg   <= o_done_next;
        o_row_reg    <= o_row_next;
        o_col_reg    <= o_col_next;
        o_cnt_reg    <= o_cnt_next;
        o_cvalid_reg <= o_cvalid_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.hue            = $signed(o_hue_reg);
    assign res.in_band        = o_inb_reg;
    assign res.frame_done     = o_done_reg;
    assign res.centroid_row   = o_row_reg;
    assign res.centroid_col   = o_col_reg;
    assign res.band_count     = o_cnt_reg;
    assign res.centroid_valid = o_cvalid_reg;

endmodule

// ===== src/rgb565_hue_band_centroid_top.sv =====
// ----------------------------------------------------------------------------
// rgb565_hue_band_centroid_top: hue band blob centroid over RGB565 frames
// Register file, pixel classifier, job queue and divider back end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Word
//  pix       in         valid/ready           pixel (RGB565)
//  res       out        valid/ready           hue, in_band, frame_done, centroid,
//                                             band_count, centroid_valid
//  APB       in/out     psel/penable, pready  band_low, band_high, sector_scale,
//                                             no_hue_value
//
//  Per pixel the back end steps through idle, the bit-serial hue divider (ordered
//  hues only), hue, band test, the bit-serial centroid divider (last pixel of a
//  frame with band pixels only) and output, and takes one pixel at a time.
//  A two-entry job queue lets the classifier take words while the back end
//  works, and the output register holds a word until res is ready.
//  Reset clears the frame position, the sums and the count, and loads the
//  register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb565_hue_band_centroid_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rhbc_pkg::DATA_W-1:0]   pwdata,
    output logic [rhbc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rhbc_pixel_if.sink                    pix,
    rhbc_result_if.source                 res
);

    logic [rhbc_pkg::HUE_W-1:0]   band_low_reg, band_low_next;
    logic [rhbc_pkg::HUE_W-1:0]   band_high_reg, band_high_next;
    logic [rhbc_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [rhbc_pkg::HUE_W-1:0]   no_hue_reg, no_hue_next;
    rhbc_pkg::reg_idx_t           reg_idx;
    logic                         wr_en;
    rhbc_pkg::cfg_t               cfg;
    logic                         push_valid;
    logic                         push_ready;
    rhbc_pkg::job_t               push_job;
    logic                         pop_valid;
    logic                         pop_ready;
    rhbc_pkg::job_t               pop_job;

    assign pready  = 1'b1;
    assign reg_idx = rhbc_pkg::reg_idx_t'(paddr[rhbc_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes.
    always_comb
    begin
        band_low_next  = band_low_reg;
        band_high_next = band_high_reg;
        scale_next     = scale_reg;
        no_hue_next    = no_hue_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rhbc_pkg::REG_BAND_LOW:     band_low_next  = pwdata[rhbc_pkg::HUE_W-1:0];
                rhbc_pkg::REG_BAND_HIGH:    band_high_next = pwdata[rhbc_pkg::HUE_W-1:0];
                rhbc_pkg::REG_SECTOR_SCALE: scale_next     = pwdata[rhbc_pkg::SCALE_W-1:0];
                rhbc_pkg::REG_NO_HUE_VALUE: no_hue_next    = pwdata[rhbc_pkg::HUE_W-1:0];
                default:                    band_low_next  = band_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg  <= '0;
            band_high_reg <= '0;
            scale_reg     <= rhbc_pkg::SCALE_W'(42);
            no_hue_reg    <= rhbc_pkg::HUE_W'(251);
        end
        else
        begin
            band_low_reg  <= band_low_next;
            band_high_reg <= band_high_next;
            scale_reg     <= scale_next;
            no_hue_reg    <= no_hue_next;
        end
    end

    // Register reads; signed bounds come back sign-extended.
    always_comb
    begin
        unique case (reg_idx)
            rhbc_pkg::REG_BAND_LOW:
                prdata = rhbc_pkg::DATA_W'($signed(band_low_reg));
            rhbc_pkg::REG_BAND_HIGH:
                prdata = rhbc_pkg::DATA_W'($signed(band_high_reg));
            rhbc_pkg::REG_SECTOR_SCALE:
                prdata = rhbc_pkg::DATA_W'(scale_reg);
            rhbc_pkg::REG_NO_HUE_VALUE:
                prdata = rhbc_pkg::DATA_W'($signed(no_hue_reg));
            default:
                prdata = '0;
        endcase
    end

    assign cfg.band_low     = band_low_reg;
    assign cfg.band_high    = band_high_reg;
    assign cfg.no_hue       = no_hue_reg;
    assign cfg.sector_scale = scale_reg;

    // Classifier.
    rhbc_front u_front
    (
        .sector_scale (scale_reg),
        .pix          (pix),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    // Queue between front and back.
    rhbc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Dividers, accumulators and output register.
    rhbc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .res       (res)
    );

endmodule

// ===== bench/tb_rgb565_hue_band_centroid_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb565_hue_band_centroid_top: self-checking bench for the hue band centroid
// A directed table and random RGB565 words drive the pixel channel under random
// source gaps and sink stalls. A behavioral copy of the hue, band and centroid
// arithmetic predicts every result word, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_rgb565_hue_band_centroid_top;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SEG_WORDS   = 240;
    localparam int SEGMENTS    = 6;
    localparam int DRAIN_TAIL  = 60;

    // One row of the directed table: a register write or a pixel word.
    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        rhbc_pkg::reg_idx_t                idx;
        logic [rhbc_pkg::DATA_W-1:0]       data;
        logic                              typed;
        logic signed [rhbc_pkg::HUE_W-1:0] exp_hue;
        logic                              exp_in_band;
    } stim_row_t;

    // Fields of one result word.
    typedef struct packed {
        logic signed [rhbc_pkg::HUE_W-1:0] hue;
        logic                              in_band;
        logic                              frame_done;
        logic [rhbc_pkg::ROW_W-1:0]        centroid_row;
        logic [rhbc_pkg::COL_W-1:0]        centroid_col;
        logic [rhbc_pkg::CNT_W-1:0]        band_count;
        logic                              centroid_valid;
    } pixel_result_t;

    localparam int STIM_ROWS = 32;
    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        // Reset defaults: black and white words have no strict channel ordering.
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_0000, 1'b1, 11'sd251, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_FFFF, 1'b1, 11'sd251, 1'b0},
        // One word per ordering: R>B>G, R>G>B, G>B>R, G>R>B.
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_801F, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_041F, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_87E0, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_07F0, 1'b0, '0, 1'b0},
        // Most negative no-hue value on a pure red word.
        '{ROW_WRITE, rhbc_pkg::REG_NO_HUE_VALUE, 32'hFFFF_FC00, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_001F, 1'b1, 11'h400, 1'b0},
        // Widest band; the largest no-hue value sits on its open upper edge.
        '{ROW_WRITE, rhbc_pkg::REG_NO_HUE_VALUE, 32'h0000_03FF, 1'b0, '0, 1'b0},
        '{ROW_WRITE, rhbc_pkg::REG_BAND_LOW, 32'hFFFF_FC00, 1'b0, '0, 1'b0},
        '{ROW_WRITE, rhbc_pkg::REG_BAND_HIGH, 32'h0000_03FF, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_F800, 1'b1, 11'sd1023, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_801F, 1'b0, '0, 1'b0},
        // Largest sector scale.
        '{ROW_WRITE, rhbc_pkg::REG_SECTOR_SCALE, 32'h0000_00FF, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_87E0, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_07F0, 1'b0, '0, 1'b0},
        // Zero sector scale: every ordered word gets hue zero.
        '{ROW_WRITE, rhbc_pkg::REG_SECTOR_SCALE, 32'h0000_0000, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_041F, 1'b1, 11'sd0, 1'b1},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_87E0, 1'b1, 11'sd0, 1'b1},
        // Smallest legal sector scale.
        '{ROW_WRITE, rhbc_pkg::REG_SECTOR_SCALE, 32'h0000_0001, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_801F, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_07F0, 1'b0, '0, 1'b0},
        // Inverted band admits nothing.
        '{ROW_WRITE, rhbc_pkg::REG_BAND_LOW, 32'h0000_0064, 1'b0, '0, 1'b0},
        '{ROW_WRITE, rhbc_pkg::REG_BAND_HIGH, 32'hFFFF_FF9C, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_87E0, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_0000, 1'b1, 11'sd1023, 1'b0},
        // Empty band: no integer lies strictly between adjacent bounds.
        '{ROW_WRITE, rhbc_pkg::REG_BAND_LOW, 32'h0000_0007, 1'b0, '0, 1'b0},
        '{ROW_WRITE, rhbc_pkg::REG_BAND_HIGH, 32'h0000_0008, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_041F, 1'b0, '0, 1'b0},
        // Back to the default scale and no-hue value; a gray word.
        '{ROW_WRITE, rhbc_pkg::REG_SECTOR_SCALE, 32'h0000_002A, 1'b0, '0, 1'b0},
        '{ROW_WRITE, rhbc_pkg::REG_NO_HUE_VALUE, 32'h0000_00FB, 1'b0, '0, 1'b0},
        '{ROW_PIXEL, rhbc_pkg::REG_BAND_LOW, 32'h0000_0841, 1'b1, 11'sd251, 1'b0}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rhbc_pkg::ADDR_W-1:0] paddr;
    logic [rhbc_pkg::DATA_W-1:0] pwdata;
    logic [rhbc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    rhbc_pixel_if  pix ();
    rhbc_result_if res ();

    // Shadow of the configuration registers.
    int band_lo;
    int band_hi;
    int hue_scale;
    int hue_none;

    // Shadow of the frame position and the band accumulators.
    int unsigned at_row;
    int unsigned at_col;
    int unsigned sum_row;
    int unsigned sum_col;
    int unsigned band_pixels;

    pixel_result_t expected_results [$];
    int            error_count  = 0;
    int            cycle_count  = 0;
    int            hold_cycles  = 0;
    int            src_odds     = 1;
    int            snk_odds     = 1;

    rgb565_hue_band_centroid_top i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix),
        .res     (res)
    );

    // Clock, 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Gap before one word: with odds N, one word in N draws a random gap, the rest none.
    function automatic int draw_gap(int odds);
        if (odds == 0)
            return 0;
        if ($urandom_range(0, odds - 1) == 0)
            return $urandom_range(0, 15);
        return 0;
    endfunction

    // Random word, biased toward channel ties and gray.
    function automatic logic [rhbc_pkg::PIX_W-1:0] random_pixel();
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = 5'($urandom);
        g6 = 6'($urandom);
        b5 = 5'($urandom);
        case ($urandom_range(0, 7))
            0: g6 = {r5, 1'b0};
            1: b5 = r5;
            2:
            begin
                b5 = g6[5:1];
                g6[0] = 1'b0;
            end
            3:
            begin
                g6 = {r5, 1'b0};
                b5 = r5;
            end
            default: ;
        endcase
        return {b5, g6, r5};
    endfunction

    // Hue band bound: mostly near the hue range, sometimes anywhere or at an extreme.
    function automatic int random_bound();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 2047)) - 1024;
            3: return ($urandom_range(0, 1) != 0) ? 1023 : -1024;
            default: return int'($urandom_range(0, 600)) - 200;
        endcase
    endfunction

    // Hue of one RGB565 word under the current scale and no-hue value.
    function automatic int pixel_hue(logic [rhbc_pkg::PIX_W-1:0] word);
        int r;
        int g;
        int b;
        r = {word[4:0], 3'b000};
        g = {word[10:5], 2'b00};
        b = {word[15:11], 3'b000};
        if (r > b && b > g)
            return ((g - b) * hue_scale) / (r - g);
        if (r > g && g > b)
            return ((g - b) * hue_scale) / (r - b);
        if (g > b && b > r)
            return ((b - r) * hue_scale) / (g - r) + 2 * hue_scale;
        if (g > r && r > b)
            return ((b - r) * hue_scale) / (g - b) + 2 * hue_scale;
        return hue_none;
    endfunction

    // Advance the frame state by one word and work out its result word.
    task automatic predict_centroid(input logic [rhbc_pkg::PIX_W-1:0] word,
                                    output pixel_result_t rw);
        int h;
        bit in_range;
        bit last;
        h = pixel_hue(word);
        in_range = (h > band_lo) && (h < band_hi);
        if (in_range)
        begin
            sum_row += at_row;
            sum_col += at_col;
            band_pixels = (band_pixels + 1) & 32'h7FFFF;
        end
        last = (at_row >= rhbc_pkg::FRAME_ROWS - 1) && (at_col >= rhbc_pkg::FRAME_COLS - 1);
        rw = '0;
        rw.hue = h[rhbc_pkg::HUE_W-1:0];
        rw.in_band = in_range;
        rw.frame_done = last;
        if (last)
        begin
            if (band_pixels != 0)
            begin
                rw.centroid_row = rhbc_pkg::ROW_W'(sum_row / band_pixels);
                rw.centroid_col = rhbc_pkg::COL_W'(sum_col / band_pixels);
                rw.centroid_valid = 1'b1;
            end
            rw.band_count = rhbc_pkg::CNT_W'(band_pixels);
            at_row = 0;
            at_col = 0;
            sum_row = 0;
            sum_col = 0;
            band_pixels = 0;
        end
        else if (at_col >= rhbc_pkg::FRAME_COLS - 1)
        begin
            at_col = 0;
            at_row = (at_row + 1) & 32'h1FF;
        end
        else
        begin
            at_col = at_col + 1;
        end
    endtask

    // Offer one word after a random gap and record its expected result.
    task automatic send_pixel(input logic [rhbc_pkg::PIX_W-1:0] word, input logic typed,
                              input logic signed [rhbc_pkg::HUE_W-1:0] exp_hue,
                              input logic exp_in);
        int gap;
        pixel_result_t rw;
        gap = draw_gap(src_odds);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= word;
        do @(posedge clk); while (!pix.ready);
        predict_centroid(word, rw);
        if (typed)
        begin
            rw.hue = exp_hue;
            rw.in_band = exp_in;
        end
        expected_results.push_back(rw);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        pix.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // One register write: setup cycle, then access until pready.
    task automatic write_reg(input rhbc_pkg::reg_idx_t idx,
                             input logic [rhbc_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rhbc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            rhbc_pkg::REG_BAND_LOW:
                band_lo   = int'($signed(data[rhbc_pkg::HUE_W-1:0]));
            rhbc_pkg::REG_BAND_HIGH:
                band_hi   = int'($signed(data[rhbc_pkg::HUE_W-1:0]));
            rhbc_pkg::REG_SECTOR_SCALE:
                hue_scale = int'(data[rhbc_pkg::SCALE_W-1:0]);
            rhbc_pkg::REG_NO_HUE_VALUE:
                hue_none  = int'($signed(data[rhbc_pkg::HUE_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic write_config(input int lo, input int hi, input int scale, input int none);
        write_reg(rhbc_pkg::REG_BAND_LOW, 32'(lo));
        write_reg(rhbc_pkg::REG_BAND_HIGH, 32'(hi));
        write_reg(rhbc_pkg::REG_SECTOR_SCALE, 32'(scale));
        write_reg(rhbc_pkg::REG_NO_HUE_VALUE, 32'(none));
    endtask

    task automatic flag_mismatch(input string field, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
        error_count++;
    endtask

    // Compare a delivered word against the oldest expectation.
    task automatic check_result(input pixel_result_t got);
        pixel_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result word with no expectation pending, hue %0d", got.hue);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.hue !== want.hue)
            flag_mismatch("hue", want.hue, got.hue);
        if (got.in_band !== want.in_band)
            flag_mismatch("in_band", want.in_band, got.in_band);
        if (got.frame_done !== want.frame_done)
            flag_mismatch("frame_done", want.frame_done, got.frame_done);
        if (got.centroid_row !== want.centroid_row)
            flag_mismatch("centroid_row", want.centroid_row, got.centroid_row);
        if (got.centroid_col !== want.centroid_col)
            flag_mismatch("centroid_col", want.centroid_col, got.centroid_col);
        if (got.band_count !== want.band_count)
            flag_mismatch("band_count", want.band_count, got.band_count);
        if (got.centroid_valid !== want.centroid_valid)
            flag_mismatch("centroid_valid", want.centroid_valid, got.centroid_valid);
    endtask

    // Result sink: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        pixel_result_t got;
        int stall;
        res.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = draw_gap(snk_odds);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
            got.hue            = res.hue;
            got.in_band        = res.in_band;
            got.frame_done     = res.frame_done;
            got.centroid_row   = res.centroid_row;
            got.centroid_col   = res.centroid_col;
            got.band_count     = res.band_count;
            got.centroid_valid = res.centroid_valid;
            check_result(got);
        end
    end

    // Main stimulus.
    initial
    begin
        stim_row_t row;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;

        // Register defaults and an empty frame.
        band_lo     = 0;
        band_hi     = 0;
        hue_scale   = 42;
        hue_none    = 251;
        at_row      = 0;
        at_col      = 0;
        sum_row     = 0;
        sum_col     = 0;
        band_pixels = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; writes wait for the block to go idle.
        for (int i = 0; i < STIM_ROWS; i++)
        begin
            row = STIM_TABLE[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_pixel(row.data[rhbc_pkg::PIX_W-1:0], row.typed, row.exp_hue,
                           row.exp_in_band);
            end
        end

        // Random segments, each under its own configuration and idling mix.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            case (seg)
                1:
                begin
                    write_config(-1024, 1023, 255, -1024);
                    src_odds = 0;
                    snk_odds = 0;
                end
                2:
                begin
                    write_config(random_bound(), random_bound(),
                                 $urandom_range(1, 255), random_bound());
                    src_odds = 0;
                    snk_odds = 1;
                    hold_cycles = 400;
                end
                4:
                begin
                    write_config(-1024, 1023, 1, 1023);
                    src_odds = 4;
                    snk_odds = 1;
                end
                5:
                begin
                    write_config(random_bound(), random_bound(),
                                 ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255),
                                 int'($urandom_range(0, 2047)) - 1024);
                    src_odds = 1;
                    snk_odds = 4;
                end
                default:
                begin
                    write_config(random_bound(), random_bound(),
                                 $urandom_range(1, 255), random_bound());
                    src_odds = 1;
                    snk_odds = 1;
                end
            endcase
            for (int k = 0; k < SEG_WORDS; k++)
            begin
                // Halfway through one segment the source waits for the sink to catch up.
                if (seg == 3 && k == SEG_WORDS / 2)
                    drain_results();
                send_pixel(random_pixel(), 1'b0, '0, 1'b0);
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== rgb565_hue_band_centroid_top.f =====
src/rhbc_pkg.sv
src/rhbc_pixel_if.sv
src/rhbc_result_if.sv
src/rhbc_front.sv
src/rhbc_queue.sv
src/rhbc_back.sv
src/rgb565_hue_band_centroid_top.sv
bench/tb_rgb565_hue_band_centroid_top.sv
